// ----- hdl/lppe_pkg.sv -----
// shared constants and types for the lidar packet point extractor
package lppe_pkg;

  localparam int unsigned PacketBytes   = 47;
  localparam int unsigned PointsPerPkt  = 12;
  localparam int unsigned AddrW         = $clog2(PacketBytes);
  localparam int unsigned PosW          = 6;

  localparam logic [7:0] HeaderByte     = 8'h54;

  // byte offsets inside a packet
  localparam logic [AddrW-1:0] StartLoAddr = AddrW'(4);
  localparam logic [AddrW-1:0] StartHiAddr = AddrW'(5);
  localparam logic [AddrW-1:0] EndLoAddr   = AddrW'(42);
  localparam logic [AddrW-1:0] EndHiAddr   = AddrW'(43);
  localparam logic [AddrW-1:0] SampleAddr  = AddrW'(6);
  localparam logic [AddrW-1:0] SampleStep  = AddrW'(3);
  localparam logic [AddrW-1:0] LastAddr    = AddrW'(PacketBytes - 1);

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgAngleOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMinDist     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxDist     = 2'd2;

  localparam logic signed [16:0] AngleOffsetRst = 17'sd0;
  localparam logic [15:0]        MinDistRst     = 16'd50;
  localparam logic [15:0]        MaxDistRst     = 16'd12000;

  typedef struct packed {
    logic signed [16:0] bearing_trim;
    logic [15:0]        min_dist;
    logic [15:0]        max_dist;
  } cfg_t;

endpackage

// ----- hdl/lppe_buf.sv -----
// packet byte store, one write port and one registered read port
module lppe_buf (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [lppe_pkg::AddrW-1:0] wr_addr_i,
  input  logic [7:0]                 wr_data_i,
  input  logic [lppe_pkg::AddrW-1:0] rd_addr_i,
  output logic [7:0]                 rd_data_o
);
  import lppe_pkg::*;

  logic [7:0] mem_q [PacketBytes];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/lppe_emit.sv -----
// read-out sequencer: angle span, per-sample bearing, filter and output beat
module lppe_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  lppe_pkg::cfg_t             cfg_i,
  output logic [lppe_pkg::AddrW-1:0] rd_addr_o,
  input  logic [7:0]                 rd_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [15:0]                angle_centideg_o,
  output logic [15:0]                range_mm_o,
  output logic                       last_point_o
);
  import lppe_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StS0    = 4'd1;
  localparam logic [3:0] StS1    = 4'd2;
  localparam logic [3:0] StE0    = 4'd3;
  localparam logic [3:0] StE1    = 4'd4;
  localparam logic [3:0] StSpan  = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StD0    = 4'd8;
  localparam logic [3:0] StD1    = 4'd9;
  localparam logic [3:0] StD2    = 4'd10;
  localparam logic [3:0] StEval  = 4'd11;
  localparam logic [3:0] StPush  = 4'd12;
  localparam logic [3:0] StFlush = 4'd13;

  localparam logic signed [17:0] FullTurn18 = 18'sd36000;
  localparam logic signed [17:0] DivBias    = 18'sd29700;   // 11 * 2700
  localparam logic signed [18:0] BiasQuot   = 19'sd2700;
  localparam logic [16:0]        Recip11    = 17'd95325;    // floor(2^20 / 11)
  localparam logic signed [18:0] FullTurn   = 19'sd36000;
  localparam logic signed [18:0] MaxAngle   = 19'sd35999;
  localparam logic [3:0]         IdxLast    = 4'(PointsPerPkt - 1);

  logic [3:0]         state_q, state_d;
  logic [15:0]        start_q;
  logic [7:0]         end_lo_q;
  logic [16:0]        span_off_q;
  logic [33:0]        prod_q;
  logic signed [18:0] qs_q, acc_q, sum_q;
  logic [3:0]         rs_q, rem_q, idx_q;
  logic [AddrW-1:0]   base_q;
  logic [15:0]        dist_q;
  logic               pass_q;
  logic               hold_valid_q, hold_valid_d;
  logic [15:0]        hold_angle_q, hold_dist_q;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_angle_q, out_dist_q;
  logic               out_last_q;

  logic               out_free, out_load, out_last_d, hold_load, advance;

  // span and its floor quotient by 11
  logic signed [17:0] span_raw, span_adj, span_off;
  logic [13:0]        q0, qf;
  logic [16:0]        r0, rf;

  // per-sample accumulation of floor(i * span / 11)
  logic [4:0]         r_sum, r_next;
  logic               carry;
  logic signed [18:0] acc_next, sum_d, ang_wrap, ang_clamp;

  always_comb begin
    span_raw = $signed({2'b00, rd_data_i, end_lo_q}) - $signed({2'b00, start_q});
    span_adj = (span_raw < 0) ? span_raw + FullTurn18 : span_raw;
    span_off = span_adj + DivBias;

    q0 = prod_q[33:20];
    r0 = span_off_q - 17'({3'b000, q0} * 17'd11);
    if (r0 >= 17'd11) begin
      qf = q0 + 14'd1;
      rf = r0 - 17'd11;
    end else begin
      qf = q0;
      rf = r0;
    end

    r_sum    = {1'b0, rem_q} + {1'b0, rs_q};
    carry    = (r_sum >= 5'd11);
    r_next   = carry ? r_sum - 5'd11 : r_sum;
    acc_next = acc_q + qs_q + (carry ? 19'sd1 : 19'sd0);

    sum_d = $signed({3'b000, start_q}) + acc_q + 19'(cfg_i.bearing_trim);

    // one wrap by a full turn, then clamp
    if (sum_q >= FullTurn) begin
      ang_wrap = sum_q - FullTurn;
    end else if (sum_q < 0) begin
      ang_wrap = sum_q + FullTurn;
    end else begin
      ang_wrap = sum_q;
    end
    if (ang_wrap < 0) begin
      ang_clamp = '0;
    end else if (ang_wrap > MaxAngle) begin
      ang_clamp = MaxAngle;
    end else begin
      ang_clamp = ang_wrap;
    end
  end

  // memory address per state
  always_comb begin
    unique case (state_q)
      StS0:    rd_addr_o = StartLoAddr;
      StS1:    rd_addr_o = StartHiAddr;
      StE0:    rd_addr_o = EndLoAddr;
      StE1:    rd_addr_o = EndHiAddr;
      StD0:    rd_addr_o = base_q;
      StD1:    rd_addr_o = base_q + AddrW'(1);
      StD2:    rd_addr_o = base_q + AddrW'(2);
      default: rd_addr_o = '0;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    hold_valid_d = hold_valid_q;
    out_load     = 1'b0;
    out_last_d   = 1'b0;
    hold_load    = 1'b0;
    advance      = 1'b0;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StS0;
      StS0:    state_d = StS1;
      StS1:    state_d = StE0;
      StE0:    state_d = StE1;
      StE1:    state_d = StSpan;
      StSpan:  state_d = StMul;
      StMul:   state_d = StDiv;
      StDiv:   state_d = StD0;
      StD0:    state_d = StD1;
      StD1:    state_d = StD2;
      StD2:    state_d = StEval;
      StEval:  state_d = StPush;
      StPush: begin
        if (!(pass_q && hold_valid_q && !out_free)) begin
          if (pass_q) begin
            out_load     = hold_valid_q;
            hold_load    = 1'b1;
            hold_valid_d = 1'b1;
          end
          advance = 1'b1;
          state_d = (idx_q == IdxLast) ? StFlush : StD0;
        end
      end
      StFlush: begin
        if (!hold_valid_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // read data arrives one state after its address: low byte, high byte, intensity
  always_ff @(posedge clk_i) begin
    case (state_q)
      StS1:   start_q[7:0]  <= rd_data_i;
      StE0:   start_q[15:8] <= rd_data_i;
      StE1:   end_lo_q      <= rd_data_i;
      StSpan: span_off_q    <= span_off[16:0];
      StMul:  prod_q        <= span_off_q * Recip11;
      StDiv: begin
        qs_q   <= $signed({5'b00000, qf}) - BiasQuot;
        rs_q   <= rf[3:0];
        acc_q  <= '0;
        rem_q  <= '0;
        idx_q  <= '0;
        base_q <= SampleAddr;
      end
      StD1:   dist_q[7:0]  <= rd_data_i;
      StD2:   dist_q[15:8] <= rd_data_i;
      StEval: sum_q        <= sum_d;
      default: ;
    endcase
    if (state_q == StEval) begin
      pass_q <= (dist_q > cfg_i.min_dist) && (dist_q < cfg_i.max_dist) &&
                (rd_data_i != 8'd0);
    end
    if (state_q == StPush && pass_q == 1'b1) begin
      pass_q <= pass_q;
    end
    if (advance) begin
      acc_q  <= acc_next;
      rem_q  <= r_next[3:0];
      idx_q  <= idx_q + 4'd1;
      base_q <= base_q + SampleStep;
    end
    if (out_load) begin
      out_angle_q <= hold_angle_q;
      out_dist_q  <= hold_dist_q;
      out_last_q  <= out_last_d;
    end
    if (hold_load) begin
      hold_angle_q <= ang_clamp[15:0];
      hold_dist_q  <= dist_q;
    end
  end

  assign busy_o           = (state_q != StIdle);
  assign out_valid_o      = out_valid_q;
  assign angle_centideg_o = out_angle_q;
  assign range_mm_o       = out_dist_q;
  assign last_point_o     = out_last_q;

endmodule

// ----- hdl/lidar_packet_point_extractor.sv -----
// top level: header hunt, packet capture, config registers and point read-out
// rate: one rx beat per cycle while hunting or gathering; after the last packet byte the
// input stalls while the read-out runs span setup, each sample and a flush, plus any output stall
// one point is held back to learn which is last: a point leaves when the next passing sample
//   is pushed, the last one in the flush; each point is one beat
// reset: hunting state, read-out idle, config at defaults; packet memory is not cleared
module lidar_packet_point_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  angle_centideg_o,
  output logic [15:0]                  range_mm_o,
  output logic                         last_point_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lppe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [16:0]                  cfg_data_i
);
  import lppe_pkg::*;

  // capture side state
  logic            in_packet_q, in_packet_d;
  logic [PosW-1:0] pos_q, pos_d;
  cfg_t            cfg_q;

  logic             in_beat, wr_en, start, busy;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       rd_data;

  // a new byte is taken whenever the read-out is idle
  assign in_ready_o = !busy;
  assign in_beat    = in_valid_i && in_ready_o;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bearing_trim <= AngleOffsetRst;
      cfg_q.min_dist     <= MinDistRst;
      cfg_q.max_dist     <= MaxDistRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAngleOffset: cfg_q.bearing_trim <= $signed(cfg_data_i);
        CfgMinDist:     cfg_q.min_dist     <= cfg_data_i[15:0];
        CfgMaxDist:     cfg_q.max_dist     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // header hunt and byte gathering
  always_comb begin
    in_packet_d = in_packet_q;
    pos_d       = pos_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q[AddrW-1:0];
    start       = 1'b0;
    if (in_beat) begin
      if (!in_packet_q) begin
        // drop everything until a header byte shows up
        if (rx_byte_i == HeaderByte) begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          pos_d       = PosW'(1);
          in_packet_d = 1'b1;
        end
      end else begin
        // header value inside a packet is plain data
        wr_en = 1'b1;
        if (pos_q[AddrW-1:0] == LastAddr) begin
          in_packet_d = 1'b0;
          pos_d       = '0;
          start       = 1'b1;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      in_packet_q <= in_packet_d;
      pos_q       <= pos_d;
    end
  end

  lppe_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (rx_byte_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // start pulses on the last byte's beat; that byte lands in memory at the same edge
  lppe_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .cfg_i            (cfg_q),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .angle_centideg_o (angle_centideg_o),
    .range_mm_o       (range_mm_o),
    .last_point_o     (last_point_o)
  );

endmodule
